// File: hdl/gif5_pkg.sv
// Shared types and constants for the 5x5 guided image filter.
// No dependencies; every other file of the block imports this package.
package gif5_pkg;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 8;
   localparam int DIM_CFG_W  = 9;
   localparam int EPS_W      = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CFG_IDX_W  = 2;
   localparam int DEN_W      = 25;
   localparam int FRAC_W     = 16;
   localparam int A_W        = 32;
   localparam int BPROD_W    = 41;
   localparam int V_W        = 42;

   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_REGULARIZER  = 2'd2;

   localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
   localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;
   localparam logic [EPS_W-1:0]     REGULARIZER_RST  = 24'd256;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD,
      ST_DRAIN,
      ST_MEAN,
      ST_COV,
      ST_LDA,
      ST_DIVA,
      ST_COEF,
      ST_BMUL,
      ST_ACC,
      ST_LDMA,
      ST_DIVMA,
      ST_LDMB,
      ST_DIVMB,
      ST_CTR,
      ST_OMUL,
      ST_OSUM
   } gif5_state_type;

endpackage

// File: hdl/gif5_req_if.sv
// Request channel of the guided filter: valid/ready plus load or compute fields.
// Depends on gif5_pkg.
interface gif5_req_if;
   import gif5_pkg::*;

   logic               valid;
   logic               ready;
   logic               func;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [PIX_W-1:0]   source_pixel;
   logic [PIX_W-1:0]   guide_pixel;

   modport source (output valid, func, col, row, source_pixel, guide_pixel, input ready);
   modport sink   (input valid, func, col, row, source_pixel, guide_pixel, output ready);
endinterface

// File: hdl/gif5_rsp_if.sv
// Result channel of the guided filter: valid/ready plus the filtered pixel.
// Depends on gif5_pkg.
interface gif5_rsp_if;
   import gif5_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] filtered_pixel;

   modport source (output valid, filtered_pixel, input ready);
   modport sink   (input valid, filtered_pixel, output ready);
endinterface

// File: hdl/guided_image_filter_5x5.sv
// Guided image filter, KERNEL_SIZE square, over stored source and guide frames.
// Load request: written into both frame memories, no result.
// Compute request: ends in a result; its run time is set by the frame reads per window and
// the one-bit-per-cycle divider for a.
// One request in work at a time; the next can be taken in the same cycle as the result first shows valid.
// Reset (synchronous) clears control and the configuration; frame memories hold.
module guided_image_filter_5x5 #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int KERNEL_SIZE = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   gif5_req_if.sink                       req_if,
   gif5_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [gif5_pkg::CFG_IDX_W-1:0] csr_idx,
   input  logic [gif5_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gif5_pkg::*;

   localparam int AREA    = KERNEL_SIZE * KERNEL_SIZE;
   localparam int HALF    = KERNEL_SIZE / 2;
   localparam int AREA_W  = $clog2(AREA + 1);
   localparam int KW      = $clog2(KERNEL_SIZE + 1);
   localparam int SUM_W   = 2 * PIX_W + AREA_W;
   localparam int RSH     = SUM_W + 8;
   localparam longint unsigned RECIP = ((64'd1 << RSH) + AREA - 1) / AREA;
   localparam int RECIP_W = RSH + 1;
   localparam int MP_W    = SUM_W + RECIP_W;
   localparam int SA_W    = A_W + AREA_W;
   localparam int SB_W    = BPROD_W + AREA_W;
   localparam int DIV_W   = 2 * PIX_W + 1 + 24;
   localparam int DCNT_W  = $clog2(DIV_W);
   localparam int DIG_W   = 2 * PIX_W;
   localparam int CDV_W   = 3 * DIG_W;
   localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int CW      = $clog2(DIM_MAX) + 2;
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(DEPTH);

   gif5_state_type state_ff, state_in;

   // configuration
   logic [DIM_CFG_W-1:0] fw_ff, fh_ff;
   logic [EPS_W-1:0]     eps_ff;
   logic signed [CW-1:0] last_col, last_row;
   logic [EPS_W-1:0]     eps_eff;

   // frame memories
   logic [PIX_W-1:0] src_ram [DEPTH];
   logic [PIX_W-1:0] gde_ram [DEPTH];
   logic [PIX_W-1:0] src_rd_ff, gde_rd_ff;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic             rd_vld_ff;

   // request position and counters
   logic signed [CW-1:0] x_ff, y_ff, x_req, y_req;
   logic signed [CW-1:0] pc_x, pc_y, cl_x, cl_y;
   logic [KW-1:0]        px_ff, py_ff, wx_ff, wy_ff;
   logic                 rd_last, win_last;

   // window sums and means
   logic [SUM_W-1:0]   si_ff, sg_ff, sii_ff, sig_ff, mean_sel, mean_q;
   logic [MP_W-1:0]    mean_prod;
   logic [1:0]         mstep_ff;
   logic [PIX_W-1:0]   mi_ff, mg_ff;
   logic [2*PIX_W-1:0] mii_ff, mig_ff;
   logic [2*PIX_W-1:0] var_u;
   logic signed [2*PIX_W+1:0] cov_s;
   logic [DEN_W-1:0]   den_c;
   logic               cov_neg_ff;
   logic [2*PIX_W:0]   cov_mag_ff;
   logic [DEN_W-1:0]   den_ff;

   // divider for a
   logic [DIV_W-1:0]  div_num_ff;
   logic [DEN_W-1:0]  div_rem_ff, div_den_ff;
   logic [DEN_W:0]    div_sh;
   logic              div_ge;
   logic              div_neg_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic              div_last, div_run;

   // digit divider by the window area for the means of a and b
   logic [CDV_W-1:0]  cdv_num_ff;
   logic [AREA_W-1:0] cdv_rem_ff, cdv_rem_c;
   logic              cdv_neg_ff;
   logic [1:0]        cdv_cnt_ff;
   logic              cdv_last, cdv_run;

   // coefficients and output
   logic signed [A_W-1:0]     a_ff, a_sat, ma_ff;
   logic signed [BPROD_W-1:0] bprod_ff, b_val, mb_ff;
   logic signed [SA_W-1:0]    sa_ff;
   logic signed [SB_W-1:0]    sb_ff;
   logic signed [V_W-1:0]     vprod_ff, v_sum;
   logic [PIX_W-1:0]          res_pix;
   logic                      rsp_valid_ff;
   logic [PIX_W-1:0]          rsp_pix_ff;
   logic                      rsp_free;

   // control decode
   logic req_ready, load_acc, comp_acc, clr_win;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FRAME_WIDTH_RST;
         fh_ff  <= FRAME_HEIGHT_RST;
         eps_ff <= REGULARIZER_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_FRAME_WIDTH:  fw_ff  <= csr_wdata[DIM_CFG_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff  <= csr_wdata[DIM_CFG_W-1:0];
            CSR_REGULARIZER:  eps_ff <= csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fw_ff == '0)                 last_col = '0;
      else if (int'(fw_ff) > MAX_WIDTH) last_col = CW'(MAX_WIDTH - 1);
      else                             last_col = CW'(fw_ff) - CW'(1);
      if (fh_ff == '0)                  last_row = '0;
      else if (int'(fh_ff) > MAX_HEIGHT) last_row = CW'(MAX_HEIGHT - 1);
      else                              last_row = CW'(fh_ff) - CW'(1);
      eps_eff = (eps_ff == '0) ? EPS_W'(1) : eps_ff;
   end

   // ---------------- state machine ----------------
   assign rd_last  = (px_ff == KW'(KERNEL_SIZE - 1)) && (py_ff == KW'(KERNEL_SIZE - 1));
   assign win_last = (wx_ff == KW'(KERNEL_SIZE - 1)) && (wy_ff == KW'(KERNEL_SIZE - 1));
   assign div_last = (div_cnt_ff == DCNT_W'(DIV_W - 1));
   assign cdv_last = (cdv_cnt_ff == 2'd2);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (comp_acc) state_in = ST_RD;
         ST_RD:    if (rd_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_MEAN;
         ST_MEAN:  if (mstep_ff == 2'd3) state_in = ST_COV;
         ST_COV:   state_in = ST_LDA;
         ST_LDA:   state_in = ST_DIVA;
         ST_DIVA:  if (div_last) state_in = ST_COEF;
         ST_COEF:  state_in = ST_BMUL;
         ST_BMUL:  state_in = ST_ACC;
         ST_ACC:   state_in = win_last ? ST_LDMA : ST_RD;
         ST_LDMA:  state_in = ST_DIVMA;
         ST_DIVMA: if (cdv_last) state_in = ST_LDMB;
         ST_LDMB:  state_in = ST_DIVMB;
         ST_DIVMB: if (cdv_last) state_in = ST_CTR;
         ST_CTR:   state_in = ST_OMUL;
         ST_OMUL:  state_in = ST_OSUM;
         ST_OSUM:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_run   = 1'b0;
      cdv_run   = 1'b0;
      clr_win   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_ACC:   clr_win   = !win_last;
         ST_DIVA:  div_run   = 1'b1;
         ST_DIVMA: cdv_run   = 1'b1;
         ST_DIVMB: cdv_run   = 1'b1;
         default: ;
      endcase
   end

   assign req_if.ready = req_ready;
   assign load_acc = req_ready && req_if.valid && (req_if.func == FUNC_LOAD);
   assign comp_acc = req_ready && req_if.valid && (req_if.func == FUNC_COMPUTE);

   // ---------------- frame memories ----------------
   assign ram_we = load_acc && (int'(req_if.col) < MAX_WIDTH) && (int'(req_if.row) < MAX_HEIGHT);
   assign ram_waddr = AW'(req_if.row) * AW'(MAX_WIDTH) + AW'(req_if.col);

   always_comb begin
      if (int'(req_if.col) > int'(last_col)) x_req = last_col;
      else                                  x_req = CW'(req_if.col);
      if (int'(req_if.row) > int'(last_row)) y_req = last_row;
      else                                  y_req = CW'(req_if.row);
   end

   // pixel of the current window, or the request centre for the final read
   always_comb begin
      if (state_ff == ST_CTR) begin
         pc_x = x_ff;
         pc_y = y_ff;
      end else begin
         pc_x = x_ff + CW'(wx_ff) + CW'(px_ff) - CW'(2 * HALF);
         pc_y = y_ff + CW'(wy_ff) + CW'(py_ff) - CW'(2 * HALF);
      end
      if (pc_x < 0)             cl_x = '0;
      else if (pc_x > last_col) cl_x = last_col;
      else                      cl_x = pc_x;
      if (pc_y < 0)             cl_y = '0;
      else if (pc_y > last_row) cl_y = last_row;
      else                      cl_y = pc_y;
   end

   assign ram_raddr = AW'(unsigned'(cl_y)) * AW'(MAX_WIDTH) + AW'(unsigned'(cl_x));

   always_ff @(posedge clock) begin
      if (ram_we) begin
         src_ram[ram_waddr] <= req_if.source_pixel;
         gde_ram[ram_waddr] <= req_if.guide_pixel;
      end
      src_rd_ff <= src_ram[ram_raddr];
      gde_rd_ff <= gde_ram[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= (state_ff == ST_RD);
   end

   // ---------------- counters and window sums ----------------
   always_ff @(posedge clock) begin
      if (comp_acc) begin
         x_ff  <= x_req;
         y_ff  <= y_req;
         wx_ff <= '0;
         wy_ff <= '0;
      end else if (state_ff == ST_ACC && !win_last) begin
         if (wx_ff == KW'(KERNEL_SIZE - 1)) begin
            wx_ff <= '0;
            wy_ff <= wy_ff + KW'(1);
         end else begin
            wx_ff <= wx_ff + KW'(1);
         end
      end

      if (comp_acc || clr_win) begin
         px_ff  <= '0;
         py_ff  <= '0;
         si_ff  <= '0;
         sg_ff  <= '0;
         sii_ff <= '0;
         sig_ff <= '0;
      end else begin
         if (state_ff == ST_RD) begin
            if (px_ff == KW'(KERNEL_SIZE - 1)) begin
               px_ff <= '0;
               py_ff <= py_ff + KW'(1);
            end else begin
               px_ff <= px_ff + KW'(1);
            end
         end
         if (rd_vld_ff) begin
            si_ff  <= si_ff + SUM_W'(src_rd_ff);
            sg_ff  <= sg_ff + SUM_W'(gde_rd_ff);
            sii_ff <= sii_ff + SUM_W'(src_rd_ff * src_rd_ff);
            sig_ff <= sig_ff + SUM_W'(src_rd_ff * gde_rd_ff);
         end
      end
   end

   // floor division by the window area through a reciprocal multiply;
   // the digit divider feeds it remainder and next 16-bit digit
   always_comb begin
      if (cdv_run) begin
         mean_sel = {cdv_rem_ff, cdv_num_ff[CDV_W-1 -: DIG_W]};
      end else begin
         case (mstep_ff)
            2'd0:    mean_sel = si_ff;
            2'd1:    mean_sel = sg_ff;
            2'd2:    mean_sel = sii_ff;
            default: mean_sel = sig_ff;
         endcase
      end
      mean_prod = MP_W'(mean_sel) * MP_W'(RECIP);
      mean_q    = SUM_W'(mean_prod >> RSH);
      cdv_rem_c = AREA_W'(mean_sel - SUM_W'(mean_q * SUM_W'(AREA)));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MEAN) begin
         mstep_ff <= mstep_ff + 2'd1;
         case (mstep_ff)
            2'd0:    mi_ff  <= (mean_q > SUM_W'(255)) ? PIX_W'(255) : mean_q[PIX_W-1:0];
            2'd1:    mg_ff  <= (mean_q > SUM_W'(255)) ? PIX_W'(255) : mean_q[PIX_W-1:0];
            2'd2:    mii_ff <= mean_q[2*PIX_W-1:0];
            default: mig_ff <= mean_q[2*PIX_W-1:0];
         endcase
      end else begin
         mstep_ff <= '0;
      end
   end

   // ---------------- variance, covariance, divisor ----------------
   always_comb begin
      var_u = mii_ff - (2*PIX_W)'(mi_ff * mi_ff);
      cov_s = $signed({2'b00, mig_ff}) - $signed({2'b00, (2*PIX_W)'(mi_ff * mg_ff)});
      den_c = (DEN_W'(var_u) << 8) + DEN_W'(eps_eff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COV) begin
         cov_neg_ff <= cov_s[2*PIX_W+1];
         cov_mag_ff <= cov_s[2*PIX_W+1] ? (2*PIX_W+1)'(-cov_s) : (2*PIX_W+1)'(cov_s);
         den_ff     <= den_c;
      end
   end

   // ---------------- restoring divider for a ----------------
   assign div_sh = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_ge = (div_sh >= {1'b0, div_den_ff});

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_LDA: begin
            div_num_ff <= DIV_W'(cov_mag_ff) << 24;
            div_den_ff <= den_ff;
            div_neg_ff <= cov_neg_ff;
         end
         default: begin
            if (div_run) begin
               div_num_ff <= {div_num_ff[DIV_W-2:0], div_ge};
               div_rem_ff <= div_ge ? DEN_W'(div_sh - {1'b0, div_den_ff}) : DEN_W'(div_sh);
            end
         end
      endcase
      if (div_run) div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      else begin
         div_cnt_ff <= '0;
         div_rem_ff <= '0;
      end
   end

   // ---------------- means of a and b, one digit per cycle ----------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_LDMA: begin
            cdv_num_ff <= sa_ff[SA_W-1] ? CDV_W'(unsigned'(-sa_ff)) : CDV_W'(unsigned'(sa_ff));
            cdv_neg_ff <= sa_ff[SA_W-1];
         end
         ST_LDMB: begin
            cdv_num_ff <= sb_ff[SB_W-1] ? CDV_W'(unsigned'(-sb_ff)) : CDV_W'(unsigned'(sb_ff));
            cdv_neg_ff <= sb_ff[SB_W-1];
         end
         default: begin
            if (cdv_run) cdv_num_ff <= {cdv_num_ff[CDV_W-DIG_W-1:0], mean_q[DIG_W-1:0]};
         end
      endcase
      if (cdv_run) begin
         cdv_cnt_ff <= cdv_cnt_ff + 2'd1;
         cdv_rem_ff <= cdv_rem_c;
      end else begin
         cdv_cnt_ff <= '0;
         cdv_rem_ff <= '0;
      end
   end

   // ---------------- coefficients ----------------
   always_comb begin
      if (div_neg_ff) begin
         if (div_num_ff > DIV_W'(64'h8000_0000)) a_sat = {1'b1, {(A_W-1){1'b0}}};
         else                                    a_sat = -$signed(div_num_ff[A_W-1:0]);
      end else begin
         if (div_num_ff > DIV_W'(64'h7FFF_FFFF)) a_sat = {1'b0, {(A_W-1){1'b1}}};
         else                                    a_sat = $signed(div_num_ff[A_W-1:0]);
      end
      b_val = (BPROD_W'($signed({1'b0, mg_ff})) <<< FRAC_W) - bprod_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COEF) a_ff <= a_sat;
      if (state_ff == ST_BMUL) bprod_ff <= BPROD_W'(a_ff) * BPROD_W'($signed({1'b0, mi_ff}));
      if (comp_acc) begin
         sa_ff <= '0;
         sb_ff <= '0;
      end else if (state_ff == ST_ACC) begin
         sa_ff <= sa_ff + SA_W'(a_ff);
         sb_ff <= sb_ff + SB_W'(b_val);
      end
      if (state_ff == ST_LDMB) begin
         ma_ff <= cdv_neg_ff ? -$signed(cdv_num_ff[A_W-1:0]) : $signed(cdv_num_ff[A_W-1:0]);
      end
      if (state_ff == ST_CTR) begin
         mb_ff <= cdv_neg_ff ? -$signed(cdv_num_ff[BPROD_W-1:0])
                             : $signed(cdv_num_ff[BPROD_W-1:0]);
      end
      if (state_ff == ST_OMUL) vprod_ff <= V_W'(ma_ff) * V_W'($signed({1'b0, src_rd_ff}));
   end

   // ---------------- result ----------------
   always_comb begin
      v_sum = vprod_ff + V_W'(mb_ff);
      if (v_sum < 0)                                  res_pix = '0;
      else if (v_sum[V_W-1:FRAC_W] > (V_W-FRAC_W)'(255)) res_pix = PIX_W'(255);
      else                                            res_pix = v_sum[FRAC_W+PIX_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OSUM && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_OSUM && rsp_free) rsp_pix_ff <= res_pix;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.filtered_pixel = rsp_pix_ff;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the 5x5 guided image filter: loads and compute requests
// with their own prediction of each filtered pixel. Needs gif5_pkg and the channel interfaces.
module testbench;
   import gif5_pkg::*;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIX_W-1:0]   src;
      logic [PIX_W-1:0]   gde;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CFG_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gif5_req_if req_ch();
   gif5_rsp_if rsp_ch();

   guided_image_filter_5x5 u_dut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // filter state as the bench sees it
   logic [PIX_W-1:0]     src_mem [65536];
   logic [PIX_W-1:0]     gde_mem [65536];
   bit                   loaded  [65536];
   logic [DIM_CFG_W-1:0] cfg_width;
   logic [DIM_CFG_W-1:0] cfg_height;
   logic [EPS_W-1:0]     cfg_eps;

   request_type       pending_reqs[$];
   logic [PIX_W-1:0]  expected_pixels[$];
   request_type       cur;
   int  send_gap, recv_gap, mismatches, idle_cycles;
   int  n_loads, n_computes, n_results;
   bit  quiet;

   function automatic int eff_dim(logic [DIM_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic int clampi(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int pix_addr(int x, int y);
      return clampi(y, 0, eff_dim(cfg_height) - 1) * 256 + clampi(x, 0, eff_dim(cfg_width) - 1);
   endfunction

   function automatic void window_ab(int px, int py, output longint a, output longint b);
      longint si, sg, sii, sig, mi, mg, vr, cv, den, iv, gv;
      int adr;
      si = 0; sg = 0; sii = 0; sig = 0;
      for (int dy = -2; dy <= 2; dy++)
         for (int dx = -2; dx <= 2; dx++) begin
            adr = pix_addr(px + dx, py + dy);
            iv = src_mem[adr];
            gv = gde_mem[adr];
            si += iv; sg += gv; sii += iv * iv; sig += iv * gv;
         end
      mi = si / 25; if (mi > 255) mi = 255;
      mg = sg / 25; if (mg > 255) mg = 255;
      vr = sii / 25 - mi * mi;
      cv = sig / 25 - mi * mg;
      den = vr * 256 + ((cfg_eps == 0) ? 1 : longint'(cfg_eps));
      if (den <= 0) den = 1;
      a = (cv * 64'sd16777216) / den;
      if (a > 64'sd2147483647) a = 64'sd2147483647;
      if (a < -64'sd2147483648) a = -64'sd2147483648;
      b = mg * 65536 - a * mi;
   endfunction

   function automatic logic [PIX_W-1:0] filtered_at(int col, int row);
      longint sa, sb, a, b, v;
      int x, y;
      x = clampi(col, 0, eff_dim(cfg_width) - 1);
      y = clampi(row, 0, eff_dim(cfg_height) - 1);
      sa = 0; sb = 0;
      for (int dy = -2; dy <= 2; dy++)
         for (int dx = -2; dx <= 2; dx++) begin
            window_ab(x + dx, y + dy, a, b);
            sa += a; sb += b;
         end
      v = (sa / 25) * longint'(src_mem[y * 256 + x]) + sb / 25;
      if (v < 0) return '0;
      v = v / 65536;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // driver
   initial begin
      req_ch.valid = 1'b0; req_ch.func = FUNC_LOAD; req_ch.col = '0; req_ch.row = '0;
      req_ch.source_pixel = '0; req_ch.guide_pixel = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0; csr_idx = CSR_FRAME_WIDTH; csr_wdata = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (cur.func == FUNC_LOAD) begin
               src_mem[{cur.row, cur.col}] = cur.src;
               gde_mem[{cur.row, cur.col}] = cur.gde;
               n_loads++;
            end else begin
               expected_pixels.push_back(filtered_at(int'(cur.col), int'(cur.row)));
               n_computes++;
            end
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the request
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur = pending_reqs.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.func         <= cur.func;
            req_ch.col          <= cur.col;
            req_ch.row          <= cur.row;
            req_ch.source_pixel <= cur.src;
            req_ch.guide_pixel  <= cur.gde;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor, stall generator and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
         idle_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: filtered_pixel=%0d", rsp_ch.filtered_pixel);
            end else begin
               logic [PIX_W-1:0] want;
               want = expected_pixels.pop_front();
               if (rsp_ch.filtered_pixel !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("filtered_pixel mismatch: expected %0d, got %0d",
                              want, rsp_ch.filtered_pixel);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) recv_gap = $urandom_range(1, 9);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 40000) begin
            $display("[guided_image_filter_5x5] ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [CFG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_idx <= idx; csr_wdata <= val;
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = val[DIM_CFG_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = val[DIM_CFG_W-1:0];
         default:          cfg_eps    = val[EPS_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_load(int x, int y, int s, int g);
      request_type r;
      r.func = FUNC_LOAD; r.col = COORD_W'(x); r.row = COORD_W'(y);
      r.src = PIX_W'(s); r.gde = PIX_W'(g);
      loaded[y * 256 + x] = 1;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_compute(int x, int y);
      request_type r;
      r.func = FUNC_COMPUTE; r.col = COORD_W'(x); r.row = COORD_W'(y);
      r.src = PIX_W'($urandom); r.gde = PIX_W'($urandom);
      pending_reqs.push_back(r);
   endtask

   // wait for the block to drain, then give loads time to settle
   task automatic wait_drained();
      wait (pending_reqs.size() == 0 && !req_ch.valid && expected_pixels.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   // configure a frame, fill every unwritten pixel of it, then mix traffic
   task automatic run_frame(int w, int h, int eps, int n_ops, bit silent);
      int ew, eh;
      wait_drained();
      quiet = silent;
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_REGULARIZER, CSR_DATA_W'(eps));
      ew = eff_dim(cfg_width); eh = eff_dim(cfg_height);
      for (int y = 0; y < eh; y++)
         for (int x = 0; x < ew; x++)
            if (!loaded[y * 256 + x]) queue_load(x, y, $urandom, $urandom);
      for (int i = 0; i < n_ops; i++) begin
         case ($urandom_range(0, 9))
            0:       queue_load($urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom, $urandom);
            1, 2:    queue_load($urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                                $urandom, $urandom);
            3:       queue_compute($urandom_range(0, 255), $urandom_range(0, 255));
            default: queue_compute($urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
         endcase
      end
   endtask

   initial begin
      cfg_width = FRAME_WIDTH_RST; cfg_height = FRAME_HEIGHT_RST; cfg_eps = REGULARIZER_RST;
      mismatches = 0; n_loads = 0; n_computes = 0; n_results = 0; quiet = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: checkerboard of extremes, corners, off-frame requests
      csr_write(CSR_FRAME_WIDTH, 6);
      csr_write(CSR_FRAME_HEIGHT, 6);
      csr_write(CSR_REGULARIZER, 1);
      for (int y = 0; y < 6; y++)
         for (int x = 0; x < 6; x++)
            queue_load(x, y, ((x + y) % 2) ? 255 : 0, ((x + y) % 2) ? 0 : 255);
      queue_load(255, 255, 255, 255);
      queue_compute(0, 0);
      queue_compute(5, 5);
      queue_compute(255, 255);
      queue_compute(2, 3);
      queue_load(3, 3, 128, 7);
      queue_compute(3, 3);
      queue_compute(0, 200);

      run_frame(1, 40, 0, 12, 0);
      run_frame(511, 1, 24'hFFFFFF, 12, 0);
      run_frame(0, 0, 256, 8, 0);
      run_frame(8, 8, $urandom_range(1, 4096), 50, 0);
      run_frame(12, 10, $urandom_range(1, 1 << 20), 50, 0);
      run_frame(256, 1, $urandom_range(1, 300), 30, 0);
      run_frame(5, 7, $urandom_range(1, 64), 50, 0);
      run_frame(4, 4, $urandom_range(1, 2048), 40, 1);

      wait_drained();
      $display("covered %0d loads and %0d compute requests (%0d results)",
               n_loads, n_computes, n_results);
      $display("frame sizes from 0 to 511, regularizer from 0 to full scale, %0d mismatches",
               mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("[guided_image_filter_5x5] OK");
      else
         $display("[guided_image_filter_5x5] ERROR");
      $finish;
   end
endmodule

// File: guided_image_filter_5x5.f
hdl/gif5_pkg.sv
hdl/gif5_req_if.sv
hdl/gif5_rsp_if.sv
hdl/guided_image_filter_5x5.sv
verif/testbench.sv
